// ===== rtl/acf_pkg.sv =====
// acf_pkg: types, codes and constants for the arm comfort and fatigue supervisor.
// No dependencies; imported by acf_classify, arm_comfort_fatigue_fsm, acf_checker and testbench.
`timescale 1ns / 1ps

package acf_pkg;

  localparam int POSITION_WIDTH = 16;
  localparam int FRACTION_BITS  = 8;
  localparam int SPEED_WIDTH    = 16;
  localparam int TOL_WIDTH      = 16;
  localparam int RATE_WIDTH     = 16;
  localparam int FATIGUE_WIDTH  = 24;
  localparam int HOLD_WIDTH     = 8;
  localparam int STATE_WIDTH    = 2;
  localparam int CFG_ADDR_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = (POSITION_WIDTH > TOL_WIDTH) ? POSITION_WIDTH : TOL_WIDTH;

  localparam logic [STATE_WIDTH-1:0] ST_STILL  = 2'd0;
  localparam logic [STATE_WIDTH-1:0] ST_MOVING = 2'd1;
  localparam logic [STATE_WIDTH-1:0] ST_RELAX  = 2'd2;

  localparam logic [FATIGUE_WIDTH-1:0] FATIGUE_MAX = {FATIGUE_WIDTH{1'b1}};
  localparam logic [HOLD_WIDTH-1:0]    HOLD_MAX    = {HOLD_WIDTH{1'b1}};
  localparam logic [HOLD_WIDTH-1:0]    RELAX_HOLD  = 8'd5;
  localparam int                       TIRED_UNITS = 100;

  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RELAX_PAN        = 3'd0;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RELAX_TILT       = 3'd1;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RELAX_RADIUS     = 3'd2;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_ANGLE_TOLERANCE  = 3'd3;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RADIUS_TOLERANCE = 3'd4;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RATE_STILL       = 3'd5;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RATE_MOVING      = 3'd6;

  typedef struct packed {
    logic                             inhibit;
    logic signed [POSITION_WIDTH-1:0] arm_pan;
    logic signed [POSITION_WIDTH-1:0] arm_tilt;
    logic signed [POSITION_WIDTH-1:0] arm_radius;
    logic signed [SPEED_WIDTH-1:0]    speed_pan;
    logic signed [SPEED_WIDTH-1:0]    speed_tilt;
    logic signed [SPEED_WIDTH-1:0]    speed_radial;
  } acf_in_t;

  typedef struct packed {
    logic [STATE_WIDTH-1:0]   state_code;
    logic [FATIGUE_WIDTH-1:0] tiredness;
    logic                     in_comfort;
    logic                     arm_moving;
    logic                     relax_request;
  } acf_out_t;

  // posture and tolerance settings seen by the classifier
  typedef struct packed {
    logic signed [POSITION_WIDTH-1:0] relax_pan;
    logic signed [POSITION_WIDTH-1:0] relax_tilt;
    logic signed [POSITION_WIDTH-1:0] relax_radius;
    logic [TOL_WIDTH-1:0]             angle_tolerance;
    logic [TOL_WIDTH-1:0]             radius_tolerance;
  } acf_posture_t;

  typedef struct packed {
    logic moving;
    logic comfort;
  } acf_class_t;

endpackage

// ===== rtl/acf_classify.sv =====
// acf_classify: motion detect and comfort-zone test for one beat.
// Depends on acf_pkg.
`timescale 1ns / 1ps

module acf_classify (
  input  acf_pkg::acf_in_t      item,
  input  acf_pkg::acf_posture_t posture,
  output acf_pkg::acf_class_t   cls
);
  import acf_pkg::*;

  localparam int DW = POSITION_WIDTH + 1;

  function automatic logic near(input logic signed [POSITION_WIDTH-1:0] a,
                                input logic signed [POSITION_WIDTH-1:0] b,
                                input logic [TOL_WIDTH-1:0] tol);
    logic signed [DW-1:0] d;
    logic [DW-1:0]        mag;
    logic [DW:0]          mag_x;
    logic [DW:0]          tol_x;
    d     = DW'(a) - DW'(b);
    mag   = d[DW-1] ? DW'(-d) : DW'(d);
    mag_x = {1'b0, mag};
    tol_x = (DW + 1)'(tol);
    return mag_x <= tol_x;
  endfunction

  always_comb begin
    cls.moving  = (item.speed_pan != '0) || (item.speed_tilt != '0) ||
                  (item.speed_radial != '0);
    cls.comfort = near(posture.relax_pan, item.arm_pan, posture.angle_tolerance) &&
                  near(posture.relax_tilt, item.arm_tilt, posture.angle_tolerance) &&
                  near(posture.relax_radius, item.arm_radius, posture.radius_tolerance);
  end

endmodule

// ===== rtl/arm_comfort_fatigue_fsm.sv =====
// arm_comfort_fatigue_fsm: top level of the arm comfort and fatigue supervisor.
// Depends on acf_pkg and acf_classify.
`timescale 1ns / 1ps

// Usage
//   One input beat per control tick on in_valid/in_ready/in_data: inhibit flag,
//   three arm positions and three axis speeds. Each accepted beat yields exactly
//   one result beat on out_valid/out_ready/out_data: state after the step,
//   tiredness (unsigned fixed point, FRACTION_BITS fraction bits), comfort and
//   motion flags and a one-beat relax request.
//   Each accepted beat passes an input register, then the classify/step logic
//   feeding the result register; out_valid rises when the result register
//   loads. Throughput is one beat per cycle while out_ready stays high, with
//   the state update done combinationally between those registers.
//   When out_ready is low the result register holds, the input register fills
//   behind it and in_ready drops; no beat is lost.
//   Configuration: cfg_we writes cfg_wdata to register cfg_addr;
//   unknown indexes are ignored. Write only while the block is idle.
//   Reset (rst_n low, synchronous) clears all settings, the state to still,
//   hold count and tiredness to zero and both flags; both pipeline slots empty.

module arm_comfort_fatigue_fsm #(
  parameter int FRACTION_BITS = acf_pkg::FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  acf_pkg::acf_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output acf_pkg::acf_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [acf_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
  input  logic [acf_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
  import acf_pkg::*;

  localparam logic [FATIGUE_WIDTH-1:0] TIRED_LIMIT =
    FATIGUE_WIDTH'(TIRED_UNITS) << FRACTION_BITS;

  // settings
  acf_posture_t          posture_r;
  logic [RATE_WIDTH-1:0] rate_still_r;
  logic [RATE_WIDTH-1:0] rate_moving_r;

  // pipeline
  logic      in_valid_r;
  acf_in_t   in_data_r;
  logic      out_valid_r;
  acf_out_t  out_data_r, out_data_nxt;
  logic      advance;

  // supervisor state
  logic [STATE_WIDTH-1:0]   state_r, state_nxt;
  logic [HOLD_WIDTH-1:0]    hold_r, hold_nxt;
  logic [FATIGUE_WIDTH-1:0] fatigue_r, fatigue_nxt;
  logic                     comfort_r, moving_r;

  acf_class_t cls;

  acf_classify u_classify (
    .item    (in_data_r),
    .posture (posture_r),
    .cls     (cls)
  );

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      posture_r     <= '0;
      rate_still_r  <= '0;
      rate_moving_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RELAX_PAN:        posture_r.relax_pan        <= POSITION_WIDTH'(cfg_wdata);
        CFG_RELAX_TILT:       posture_r.relax_tilt       <= POSITION_WIDTH'(cfg_wdata);
        CFG_RELAX_RADIUS:     posture_r.relax_radius     <= POSITION_WIDTH'(cfg_wdata);
        CFG_ANGLE_TOLERANCE:  posture_r.angle_tolerance  <= TOL_WIDTH'(cfg_wdata);
        CFG_RADIUS_TOLERANCE: posture_r.radius_tolerance <= TOL_WIDTH'(cfg_wdata);
        CFG_RATE_STILL:       rate_still_r               <= RATE_WIDTH'(cfg_wdata);
        CFG_RATE_MOVING:      rate_moving_r              <= RATE_WIDTH'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // step logic
  logic [RATE_WIDTH-1:0]    rate;
  logic [FATIGUE_WIDTH-1:0] rate_x;
  logic [FATIGUE_WIDTH:0]   sum;
  logic [FATIGUE_WIDTH-1:0] tired;
  logic                     req;
  logic                     relax_go;

  always_comb begin
    rate   = (state_r == ST_MOVING) ? rate_moving_r : rate_still_r;
    rate_x = FATIGUE_WIDTH'(rate);
    sum    = {1'b0, fatigue_r} + {1'b0, rate_x};
    if (cls.comfort) begin
      tired = (fatigue_r > rate_x) ? fatigue_r - rate_x : '0;
    end else begin
      tired = sum[FATIGUE_WIDTH] ? FATIGUE_MAX : sum[FATIGUE_WIDTH-1:0];
    end
    relax_go = !cls.comfort && (tired > TIRED_LIMIT) && (hold_r != '0);

    state_nxt   = state_r;
    fatigue_nxt = fatigue_r;
    req         = 1'b0;
    unique case (state_r)
      ST_MOVING: begin
        fatigue_nxt = tired;
        if (!cls.moving) state_nxt = ST_STILL;
        else if (relax_go) state_nxt = ST_RELAX;
      end
      ST_RELAX: begin
        if (hold_r == '0) begin
          req         = 1'b1;
          fatigue_nxt = fatigue_r >> 1;
        end else if (hold_r > RELAX_HOLD) begin
          state_nxt = cls.moving ? ST_MOVING : ST_STILL;
        end
      end
      default: begin
        // still, and the unused code behaves as still
        fatigue_nxt = tired;
        if (cls.moving) state_nxt = ST_MOVING;
        else if (relax_go) state_nxt = ST_RELAX;
      end
    endcase

    if (state_nxt != state_r) hold_nxt = '0;
    else if (hold_r != HOLD_MAX) hold_nxt = hold_r + 1'b1;
    else hold_nxt = hold_r;

    if (in_data_r.inhibit) begin
      out_data_nxt.state_code    = state_r;
      out_data_nxt.tiredness     = fatigue_r;
      out_data_nxt.in_comfort    = comfort_r;
      out_data_nxt.arm_moving    = moving_r;
      out_data_nxt.relax_request = 1'b0;
    end else begin
      out_data_nxt.state_code    = state_nxt;
      out_data_nxt.tiredness     = fatigue_nxt;
      out_data_nxt.in_comfort    = cls.comfort;
      out_data_nxt.arm_moving    = cls.moving;
      out_data_nxt.relax_request = req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_STILL;
      hold_r      <= '0;
      fatigue_r   <= '0;
      comfort_r   <= 1'b0;
      moving_r    <= 1'b0;
    end else begin
      if (in_ready) in_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (advance && !in_data_r.inhibit) begin
        state_r   <= state_nxt;
        hold_r    <= hold_nxt;
        fatigue_r <= fatigue_nxt;
        comfort_r <= cls.comfort;
        moving_r  <= cls.moving;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_data_r <= in_data;
    if (advance) out_data_r <= out_data_nxt;
  end

endmodule

// ===== bench/acf_checker.sv =====
// acf_checker: watches the tick, result and settings ports of the arm comfort and
// fatigue supervisor, predicts every result beat and compares it field by field.
// Depends on acf_pkg for the beat types, state codes and register indexes.
`timescale 1ns / 1ps

module acf_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  acf_pkg::acf_in_t                   in_data,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  acf_pkg::acf_out_t                  out_data,
  input  logic                               cfg_we,
  input  logic [acf_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  logic [acf_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output int                                 mismatches,
  output int                                 waiting
);
  import acf_pkg::*;

  localparam logic [FATIGUE_WIDTH-1:0] TIRED_LIMIT =
    FATIGUE_WIDTH'(TIRED_UNITS << FRACTION_BITS);

  // shadow of the settings registers
  logic signed [POSITION_WIDTH-1:0] posture_pan, posture_tilt, posture_radius;
  logic [TOL_WIDTH-1:0]             angle_tol, radius_tol;
  logic [RATE_WIDTH-1:0]            still_rate, moving_rate;

  // supervisor state as predicted
  logic [STATE_WIDTH-1:0]   mode;
  logic [HOLD_WIDTH-1:0]    held_ticks;
  logic [FATIGUE_WIDTH-1:0] fatigue_level;
  logic                     comfort_now, moving_now;

  acf_out_t expected_ticks[$];
  int       errors = 0;

  function automatic logic near_axis(logic signed [POSITION_WIDTH-1:0] centre,
                                     logic signed [POSITION_WIDTH-1:0] pos,
                                     logic [TOL_WIDTH-1:0] tol);
    int d;
    d = int'(pos) - int'(centre);
    if (d < 0) d = -d;
    return d <= int'(tol);
  endfunction

  function automatic logic [FATIGUE_WIDTH-1:0] tire(logic [FATIGUE_WIDTH-1:0] f,
                                                    logic [RATE_WIDTH-1:0] rate,
                                                    logic comfort);
    logic [FATIGUE_WIDTH:0] sum;
    if (comfort) return (f > rate) ? f - rate : '0;
    sum = {1'b0, f} + rate;
    return (sum > FATIGUE_MAX) ? FATIGUE_MAX : sum[FATIGUE_WIDTH-1:0];
  endfunction

  task automatic advance(input acf_in_t beat, output acf_out_t res);
    logic [STATE_WIDTH-1:0] nxt;
    logic                   pulse;
    nxt = mode;
    pulse = 1'b0;
    if (!beat.inhibit) begin
      moving_now = (beat.speed_pan != 0) || (beat.speed_tilt != 0) ||
                   (beat.speed_radial != 0);
      comfort_now = near_axis(posture_pan, beat.arm_pan, angle_tol) &&
                    near_axis(posture_tilt, beat.arm_tilt, angle_tol) &&
                    near_axis(posture_radius, beat.arm_radius, radius_tol);
      case (mode)
        ST_MOVING: begin
          fatigue_level = tire(fatigue_level, moving_rate, comfort_now);
          if (!moving_now) nxt = ST_STILL;
          else if (!comfort_now && fatigue_level > TIRED_LIMIT && held_ticks != 0)
            nxt = ST_RELAX;
        end
        ST_RELAX: begin
          if (held_ticks == 0) begin
            pulse = 1'b1;
            fatigue_level = fatigue_level >> 1;
          end else if (held_ticks > RELAX_HOLD) begin
            nxt = moving_now ? ST_MOVING : ST_STILL;
          end
        end
        default: begin
          // an unused code behaves as still
          fatigue_level = tire(fatigue_level, still_rate, comfort_now);
          if (moving_now) nxt = ST_MOVING;
          else if (!comfort_now && fatigue_level > TIRED_LIMIT && held_ticks != 0)
            nxt = ST_RELAX;
        end
      endcase
      if (nxt != mode) begin
        mode = nxt;
        held_ticks = '0;
      end else if (held_ticks != HOLD_MAX) begin
        held_ticks++;
      end
    end
    res.state_code    = mode;
    res.tiredness     = fatigue_level;
    res.in_comfort    = comfort_now;
    res.arm_moving    = moving_now;
    res.relax_request = pulse;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    acf_out_t want;
    if (!rst_n) begin
      posture_pan = '0;
      posture_tilt = '0;
      posture_radius = '0;
      angle_tol = '0;
      radius_tol = '0;
      still_rate = '0;
      moving_rate = '0;
      mode = ST_STILL;
      held_ticks = '0;
      fatigue_level = '0;
      comfort_now = 1'b0;
      moving_now = 1'b0;
      expected_ticks.delete();
    end else begin
      // result first: it belongs to an earlier tick than any beat taken now
      if (out_valid && out_ready) begin
        if (expected_ticks.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, got %h",
                   $time, out_data);
          errors++;
        end else begin
          want = expected_ticks.pop_front();
          check_field("state_code", 32'(want.state_code), 32'(out_data.state_code));
          check_field("tiredness", 32'(want.tiredness), 32'(out_data.tiredness));
          check_field("in_comfort", 32'(want.in_comfort), 32'(out_data.in_comfort));
          check_field("arm_moving", 32'(want.arm_moving), 32'(out_data.arm_moving));
          check_field("relax_request", 32'(want.relax_request),
                      32'(out_data.relax_request));
        end
      end
      if (in_valid && in_ready) begin
        advance(in_data, want);
        expected_ticks.push_back(want);
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_RELAX_PAN:        posture_pan = cfg_wdata;
          CFG_RELAX_TILT:       posture_tilt = cfg_wdata;
          CFG_RELAX_RADIUS:     posture_radius = cfg_wdata;
          CFG_ANGLE_TOLERANCE:  angle_tol = cfg_wdata;
          CFG_RADIUS_TOLERANCE: radius_tol = cfg_wdata;
          CFG_RATE_STILL:       still_rate = cfg_wdata;
          CFG_RATE_MOVING:      moving_rate = cfg_wdata;
          default: ;
        endcase
      end
    end
    mismatches <= errors;
    waiting <= expected_ticks.size();
  end

endmodule

// ===== bench/testbench.sv =====
// testbench: drives ticks and settings into arm_comfort_fatigue_fsm with random
// gaps and result stalls; acf_checker predicts and compares, this module decides.
// Depends on acf_pkg, acf_checker and the supervisor RTL.
`timescale 1ns / 1ps

module testbench;
  import acf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SPARE = 3'd7;

  typedef enum {STILL_AWAY, STILL_NEAR, MOVE_AWAY, MOVE_NEAR, ALTERNATE, NOISE} tick_kind_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  acf_in_t                   in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b1;
  acf_out_t                  out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_addr = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_wdata = '0;

  int          mismatches;
  int          waiting;
  int unsigned cycles = 0;
  int          in_gap_pct = 0;
  int          out_gap_pct = 0;

  // posture and tolerances last written, used to aim ticks near the relax posture
  int pan_at = 0, tilt_at = 0, radius_at = 0, angle_at = 0, reach_at = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  arm_comfort_fatigue_fsm dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  acf_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .waiting(waiting)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : stall
    int gap;
    forever begin
      @(negedge clk);
      if (out_gap_pct != 0 && $urandom_range(1, 100) <= out_gap_pct) begin
        gap = $urandom_range(1, 19);
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  function automatic logic [15:0] close_to(int centre, int tol);
    int off, p;
    off = ($urandom_range(0, 3) == 0) ? tol : int'($urandom_range(0, tol));
    p = $urandom_range(0, 1) ? centre + off : centre - off;
    if (p > 32767) p = centre - off;
    if (p < -32768) p = centre + off;
    if (p > 32767) p = 32767;
    return 16'(p);
  endfunction

  function automatic logic [15:0] spin();
    logic [15:0] v;
    v = 16'($urandom);
    if (v == 0) v = 16'h8000;
    return v;
  endfunction

  function automatic acf_in_t mk(logic inh, int pan, int tilt, int rad,
                                 int sp, int st, int sr);
    acf_in_t t;
    t.inhibit = inh;
    t.arm_pan = 16'(pan);
    t.arm_tilt = 16'(tilt);
    t.arm_radius = 16'(rad);
    t.speed_pan = 16'(sp);
    t.speed_tilt = 16'(st);
    t.speed_radial = 16'(sr);
    return t;
  endfunction

  function automatic acf_in_t make_tick(tick_kind_t kind);
    acf_in_t t;
    bit      moving, near;
    t = '0;
    moving = (kind == MOVE_AWAY || kind == MOVE_NEAR);
    near = (kind == STILL_NEAR || kind == MOVE_NEAR);
    if (kind == NOISE) begin
      t.inhibit = 1'($urandom_range(0, 1));
      t.arm_pan = 16'($urandom);
      t.arm_tilt = 16'($urandom);
      t.arm_radius = 16'($urandom);
      t.speed_pan = 16'($urandom);
      t.speed_tilt = 16'($urandom);
      t.speed_radial = 16'($urandom);
      return t;
    end
    t.inhibit = ($urandom_range(0, 11) == 0);
    if (near) begin
      t.arm_pan = close_to(pan_at, angle_at);
      t.arm_tilt = close_to(tilt_at, angle_at);
      t.arm_radius = close_to(radius_at, reach_at);
    end else begin
      t.arm_pan = 16'($urandom);
      t.arm_tilt = 16'($urandom);
      t.arm_radius = 16'($urandom);
    end
    if (moving) begin
      if ($urandom_range(0, 1) != 0) t.speed_pan = spin();
      if ($urandom_range(0, 1) != 0) t.speed_tilt = spin();
      if ($urandom_range(0, 1) != 0) t.speed_radial = spin();
      if (t.speed_pan == 0 && t.speed_tilt == 0) t.speed_radial = spin();
    end
    return t;
  endfunction

  // one beat, with an optional gap in front; valid stays up until taken
  task automatic send_tick(input acf_in_t beat);
    int gap;
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
  endtask

  task automatic configure(input int pan, input int tilt, input int rad, input int atol,
                           input int rtol, input int rstill, input int rmoving);
    pan_at = pan;
    tilt_at = tilt;
    radius_at = rad;
    angle_at = atol;
    reach_at = rtol;
    write_reg(CFG_RELAX_PAN, 16'(pan));
    write_reg(CFG_RELAX_TILT, 16'(tilt));
    write_reg(CFG_RELAX_RADIUS, 16'(rad));
    write_reg(CFG_ANGLE_TOLERANCE, 16'(atol));
    write_reg(CFG_RADIUS_TOLERANCE, 16'(rtol));
    write_reg(CFG_RATE_STILL, 16'(rstill));
    write_reg(CFG_RATE_MOVING, 16'(rmoving));
    // unmapped index: must leave every setting alone
    write_reg(CFG_SPARE, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (waiting != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    tick_kind_t kind;
    int         run, left;
    left = count;
    while (left > 0) begin
      kind = tick_kind_t'($urandom_range(0, 5));
      run = $urandom_range(1, 14);
      for (int i = 0; i < run && left > 0; i++) begin
        if (kind == ALTERNATE) send_tick(make_tick((i % 2 != 0) ? MOVE_AWAY : STILL_AWAY));
        else send_tick(make_tick(kind));
        left--;
      end
    end
  endtask

  task automatic random_settings(input int tol_max);
    configure(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
              int'($urandom_range(0, 65535)) - 32768, $urandom_range(0, tol_max),
              $urandom_range(0, tol_max), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
  endtask

  initial begin : stimulus
    acf_in_t t;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset settings first
    in_gap_pct = 30;
    out_gap_pct = 30;
    send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    send_tick(mk(1, 32767, -32768, 32767, -32768, 32767, 1));
    send_tick(mk(0, -32768, 32767, -32768, 0, 0, -1));
    settle();

    // fast rates so that relax is reached within a few ticks
    configure(0, 0, 0, 1000, 500, 16'h4000, 16'h8000);
    send_tick(mk(0, 5000, 0, 0, 0, 0, 0));
    send_tick(mk(0, 5000, 0, 0, 0, 0, 0));
    send_tick(mk(0, 5000, 0, 0, 0, 0, 0));   // first relax tick
    send_tick(mk(0, 5000, 0, 0, 0, 0, 0));
    send_tick(mk(1, 0, 0, 0, 0, 0, 0));      // inhibited while relaxing
    repeat (4) send_tick(mk(0, 5000, 0, 0, 0, 0, 0));
    send_tick(mk(0, 5000, 0, 0, 1, 0, 0));   // hold exceeded, leave for moving
    send_tick(mk(0, 1000, -1000, 500, 0, -1, 0));
    send_tick(mk(0, 1001, -1000, 500, 0, 0, 7));
    send_tick(mk(0, -9000, 20000, 3000, 0, 0, 7));
    settle();

    // extreme posture and widest tolerances
    configure(-32768, 32767, -32768, 65535, 65535, 65535, 65535);
    send_tick(mk(0, 32767, -32768, 32767, 0, 0, 0));
    send_tick(mk(0, -32768, 32767, -32768, 0, -32768, 0));
    random_phase(100);
    settle();

    in_gap_pct = 0;
    out_gap_pct = 0;
    random_settings(3000);
    random_phase(100);
    settle();

    // zero rates, zero tolerance, opposite extreme posture
    in_gap_pct = 50;
    out_gap_pct = 10;
    configure(32767, -32768, 32767, 0, 0, 0, 0);
    random_phase(60);
    settle();

    // alternating still and moving keeps the hold at zero: tiredness saturates,
    // then a long still stretch in comfort drains it and saturates the hold count
    in_gap_pct = 10;
    out_gap_pct = 40;
    configure(0, 0, 0, 0, 0, 65535, 65535);
    for (int i = 0; i < 270; i++) begin
      t = make_tick((i % 2 != 0) ? MOVE_AWAY : STILL_AWAY);
      t.inhibit = 1'b0;
      send_tick(t);
    end
    repeat (270) send_tick(mk(0, 0, 0, 0, 0, 0, 0));
    settle();

    in_gap_pct = 30;
    out_gap_pct = 30;
    random_settings(65535);
    random_phase(80);
    settle();

    in_gap_pct = 0;
    out_gap_pct = 0;
    random_settings(4000);
    random_phase(80);
    settle();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
